/* sv/keyword_trie_builder_macros.svh */
// Assertion macros used by the trie builder.
`ifndef KEYWORD_TRIE_BUILDER_MACROS_SVH
`define KEYWORD_TRIE_BUILDER_MACROS_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define KTB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define KTB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ktb_pkg.sv */
package ktb_pkg;

  // Sizing of the trie
  localparam int NODE_DEPTH = 1024;
  localparam int ALPHABET   = 26;
  localparam int MAX_WORDS  = 64;
  localparam int LETTERS    = 26;

  localparam int NODE_W     = $clog2(NODE_DEPTH);
  localparam int NFF_W      = $clog2(NODE_DEPTH + 1);
  localparam int TABLE_SIZE = NODE_DEPTH * ALPHABET;
  localparam int ADDR_W     = $clog2(TABLE_SIZE);
  localparam int WORD_W     = $clog2(MAX_WORDS + 1);

  // Fixed port widths
  localparam int LETTER_W   = 5;
  localparam int COL_W      = 5;
  localparam int OUT_NODE_W = 10;
  localparam int WORD_ID_W  = 7;
  localparam int STATUS_W   = 2;

  // Actions
  localparam logic ACT_DECLARE = 1'b0;
  localparam logic ACT_INSERT  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDECL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_WORDS  = 2'd3;

  // Transition store access requests
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [NODE_W-1:0] data;
  } mem_wr_req_t;

endpackage

/* sv/keyword_trie_builder.sv */
// Channel   Ports                                          Handshake
// input     in_action, in_letter, in_last_of_word          start & !busy
// result    out_letter_column .. out_status                out_strobe, one cycle
//
// A declare beat ends in its accepting cycle; an insert beat reads the table at
// the walk node, then writes a new transition in S_LOOK, since the read of the
// transition memory is registered. An undeclared insert letter ends like a
// declare beat. After reset, busy stays high while the transition memory is
// swept to empty. The result appears in the cycle after the beat's last cycle;
// the receiver cannot stall it, and a new beat may be accepted while a result
// is on the ports.
`include "keyword_trie_builder_macros.svh"

module keyword_trie_builder
  import ktb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_action,
  input  logic [LETTER_W-1:0]   in_letter,
  input  logic                  in_last_of_word,
  output logic                  out_strobe,
  output logic [COL_W-1:0]      out_letter_column,
  output logic [OUT_NODE_W-1:0] out_from_node,
  output logic [OUT_NODE_W-1:0] out_to_node,
  output logic                  out_created,
  output logic [WORD_ID_W-1:0]  out_word_id,
  output logic [STATUS_W-1:0]   out_status
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LOOK = 1'b1;

  logic                  state_r, state_nxt;
  logic [NODE_W-1:0]     walk_r, walk_nxt;
  logic [NFF_W-1:0]      nff_r, nff_nxt;
  logic [WORD_W-1:0]     words_r, words_nxt;
  logic [COL_W-1:0]      cnt_r, cnt_nxt;
  logic [COL_W-1:0]      col_map_r [LETTERS];
  logic [LETTERS-1:0]    col_set_r;

  // Pending insert beat
  logic [COL_W-1:0]      col_p_r;
  logic [ADDR_W-1:0]     addr_p_r;
  logic                  last_p_r;

  // Result registers
  logic                  ov_r, ov_nxt;
  logic [COL_W-1:0]      ocol_r, ocol_nxt;
  logic [NODE_W-1:0]     ofrom_r, ofrom_nxt;
  logic [NODE_W-1:0]     oto_r, oto_nxt;
  logic                  ocr_r, ocr_nxt;
  logic [WORD_ID_W-1:0]  oword_r, oword_nxt;
  logic [STATUS_W-1:0]   ost_r, ost_nxt;

  logic                  clearing;
  logic                  acc;
  logic                  letter_ok;
  logic                  lk_set;
  logic [COL_W-1:0]      lk_col;
  logic                  map_we;
  logic [ADDR_W-1:0]     rd_addr;
  logic [NODE_W-1:0]     rd_data;
  mem_rd_req_t           rd_req;
  mem_wr_req_t           wr_req;

  ktb_trans_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_req   (rd_req),
    .wr_req   (wr_req),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  assign busy = clearing | (state_r == S_LOOK);
  assign acc  = start & ~busy;

  // Column lookup for the incoming letter
  always_comb begin
    letter_ok = in_letter < LETTER_W'(ALPHABET);
    lk_set    = letter_ok ? col_set_r[in_letter] : 1'b0;
    lk_col    = letter_ok ? col_map_r[in_letter] : '0;
    rd_addr   = ADDR_W'(walk_r) * ADDR_W'(ALPHABET) + ADDR_W'(lk_col);
  end

  always_comb begin
    rd_req.en   = acc & (in_action == ACT_INSERT) & lk_set;
    rd_req.addr = rd_addr;
  end

  // Main step logic
  always_comb begin
    state_nxt = state_r;
    walk_nxt  = walk_r;
    nff_nxt   = nff_r;
    words_nxt = words_r;
    cnt_nxt   = cnt_r;
    map_we    = 1'b0;
    ov_nxt    = 1'b0;
    ocol_nxt  = ocol_r;
    ofrom_nxt = ofrom_r;
    oto_nxt   = oto_r;
    ocr_nxt   = ocr_r;
    oword_nxt = oword_r;
    ost_nxt   = ost_r;
    wr_req.en   = 1'b0;
    wr_req.addr = addr_p_r;
    wr_req.data = NODE_W'(nff_r);

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_action == ACT_DECLARE) begin
            ov_nxt    = 1'b1;
            ofrom_nxt = '0;
            oto_nxt   = '0;
            oword_nxt = '0;
            if (!letter_ok) begin
              ocol_nxt = '0;
              ocr_nxt  = 1'b0;
              ost_nxt  = ST_UNDECL;
            end else if (!lk_set) begin
              map_we   = 1'b1;
              cnt_nxt  = cnt_r + 1'b1;
              ocol_nxt = cnt_r;
              ocr_nxt  = 1'b1;
              ost_nxt  = ST_OK;
            end else begin
              ocol_nxt = lk_col;
              ocr_nxt  = 1'b0;
              ost_nxt  = ST_OK;
            end
          end else if (!lk_set) begin
            // undeclared or out-of-range letter: walk stays put
            ov_nxt    = 1'b1;
            ocol_nxt  = '0;
            ofrom_nxt = walk_r;
            oto_nxt   = walk_r;
            ocr_nxt   = 1'b0;
            oword_nxt = '0;
            ost_nxt   = ST_UNDECL;
          end else begin
            state_nxt = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        state_nxt = S_IDLE;
        ov_nxt    = 1'b1;
        ocol_nxt  = col_p_r;
        ofrom_nxt = walk_r;
        oword_nxt = '0;
        ost_nxt   = ST_OK;
        ocr_nxt   = 1'b0;
        oto_nxt   = rd_data;
        if (rd_data == '0 && nff_r >= NFF_W'(NODE_DEPTH)) begin
          // node store full: nothing changes
          oto_nxt = walk_r;
          ost_nxt = ST_FULL;
        end else begin
          if (rd_data == '0) begin
            wr_req.en = 1'b1;
            oto_nxt   = NODE_W'(nff_r);
            ocr_nxt   = 1'b1;
            nff_nxt   = nff_r + 1'b1;
          end
          walk_nxt = oto_nxt;
          if (last_p_r) begin
            walk_nxt = '0;
            if (words_r >= WORD_W'(MAX_WORDS)) begin
              ost_nxt = ST_WORDS;
            end else begin
              words_nxt = words_r + 1'b1;
              oword_nxt = WORD_ID_W'(words_nxt);
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      walk_r    <= '0;
      nff_r     <= NFF_W'(1);
      words_r   <= '0;
      cnt_r     <= '0;
      col_set_r <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      walk_r  <= walk_nxt;
      nff_r   <= nff_nxt;
      words_r <= words_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
      if (map_we) begin
        col_set_r[in_letter] <= 1'b1;
      end
    end
  end

  // Payload: column map entries, pending beat, result fields
  always_ff @(posedge clk) begin
    if (map_we) begin
      col_map_r[in_letter] <= cnt_r;
    end
    if (rd_req.en) begin
      col_p_r  <= lk_col;
      addr_p_r <= rd_addr;
      last_p_r <= in_last_of_word;
    end
    ocol_r  <= ocol_nxt;
    ofrom_r <= ofrom_nxt;
    oto_r   <= oto_nxt;
    ocr_r   <= ocr_nxt;
    oword_r <= oword_nxt;
    ost_r   <= ost_nxt;
  end

  assign out_strobe        = ov_r;
  assign out_letter_column = ocol_r;
  assign out_from_node     = OUT_NODE_W'(ofrom_r);
  assign out_to_node       = OUT_NODE_W'(oto_r);
  assign out_created       = ocr_r;
  assign out_word_id       = oword_r;
  assign out_status        = ost_r;

  // Checks
  `KTB_ASSERT_NXT(a_decl_one_cycle, acc && in_action == ACT_DECLARE, out_strobe, "declare beat gave no result next cycle")
  `KTB_ASSERT_NXT(a_ins_two_cycle, rd_req.en, !out_strobe ##1 out_strobe, "insert beat result not after two cycles")
  `KTB_ASSERT_IMP(a_full_holds, out_strobe && out_status == ST_FULL, out_to_node == out_from_node && !out_created, "full store moved the walk")
  `KTB_ASSERT_IMP(a_nff_bound, 1'b1, nff_r <= NFF_W'(NODE_DEPTH) && nff_r != '0, "node counter out of range")
  `KTB_ASSERT_IMP(a_no_write_clear, clearing, !wr_req.en && !rd_req.en, "table access during clearing sweep")

endmodule

/* sv/ktb_trans_store.sv */
module ktb_trans_store
  import ktb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  mem_rd_req_t       rd_req,
  input  mem_wr_req_t       wr_req,
  output logic [NODE_W-1:0] rd_data,
  output logic              clearing
);

  // Transition table, one entry per node and column; 0 is empty
  logic [NODE_W-1:0] mem [TABLE_SIZE];

  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic              clearing_r, clearing_nxt;
  logic [NODE_W-1:0] rd_data_r;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [NODE_W-1:0] wdata;

  // Clearing sweep after reset, one entry a cycle
  always_comb begin
    clr_nxt      = clr_r;
    clearing_nxt = clearing_r;
    if (clearing_r) begin
      if (clr_r == ADDR_W'(TABLE_SIZE - 1)) begin
        clearing_nxt = 1'b0;
      end else begin
        clr_nxt = clr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= '0;
      clearing_r <= 1'b1;
    end else begin
      clr_r      <= clr_nxt;
      clearing_r <= clearing_nxt;
    end
  end

  // Write port: sweep has priority
  always_comb begin
    we    = clearing_r | wr_req.en;
    waddr = clearing_r ? clr_r : wr_req.addr;
    wdata = clearing_r ? '0 : wr_req.data;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_req.en) begin
      rd_data_r <= mem[rd_req.addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clearing_r;

endmodule
